// ----- hw/rtl/aamd_pkg.sv -----
package aamd_pkg;

    // Default for the widest source image, in pixels.
    localparam int MAX_WIDTH_DEF = 2048;
    // Source height is always limited to this many rows.
    localparam int HEIGHT_LIMIT  = 2048;
    localparam int CFG_W         = 12;
    localparam int ROW_W         = 11;
    localparam int CHAN_W        = 8;
    localparam int TDATA_W       = 32;
    localparam int PAIR_W        = CHAN_W + 1;
    // Line store entry: 9-bit blue, green and red pair sums and a 2-bit count.
    localparam int SUM_W         = 3 * PAIR_W + 2;

    localparam logic [CHAN_W-1:0] OPAQUE = 8'd255;

    // Division by three as a multiply by 683/2048; exact for inputs up to 765.
    localparam logic [10:0] RECIP3       = 11'd683;
    localparam int          RECIP3_SHIFT = 11;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_HAS_ALPHA    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMBINE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
        logic             has_alpha;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic combine;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic produce;
    } t_status;

    function automatic logic [CHAN_W-1:0] div3(input logic [9:0] sum);
        logic [20:0] prod;
        prod = 21'(sum) * 21'(RECIP3);
        return prod[RECIP3_SHIFT+CHAN_W-1:RECIP3_SHIFT];
    endfunction

endpackage

// ----- hw/rtl/aamd_cfg.sv -----
module aamd_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [aamd_pkg::CFG_W-1:0] i_cfg_data,
    output aamd_pkg::t_cfg            o_cfg
);
    import aamd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= CFG_W'(2);
            r_cfg.image_height <= CFG_W'(2);
            r_cfg.has_alpha    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data;
                CFG_HAS_ALPHA:    r_cfg.has_alpha    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/aamd_dpath.sv -----
module aamd_dpath #(
    parameter int MAX_WIDTH = aamd_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  aamd_pkg::t_cfg              i_cfg,
    input  aamd_pkg::t_cmd              i_cmd,
    input  logic                        i_first_of_image,
    input  logic [aamd_pkg::CHAN_W-1:0] i_in_blue,
    input  logic [aamd_pkg::CHAN_W-1:0] i_in_green,
    input  logic [aamd_pkg::CHAN_W-1:0] i_in_red,
    input  logic [aamd_pkg::CHAN_W-1:0] i_in_alpha,
    output aamd_pkg::t_status           o_status,
    output logic [aamd_pkg::CHAN_W-1:0] o_out_blue,
    output logic [aamd_pkg::CHAN_W-1:0] o_out_green,
    output logic [aamd_pkg::CHAN_W-1:0] o_out_red,
    output logic [aamd_pkg::CHAN_W-1:0] o_out_alpha,
    output logic                        o_last_of_image
);
    import aamd_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HW    = CFG_W;

    // Position counters and the held left pixel of a pair.
    logic [XW-1:0]     r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [3*CHAN_W-1:0] r_hold_pix;
    logic              r_hold_cnt;

    // Line store of upper-row pair sums.
    logic [SUM_W-1:0]  r_mem [DEPTH];
    logic [SUM_W-1:0]  r_rd;

    // Lower-row pair sums waiting for the stored upper sums.
    logic [PAIR_W-1:0] r_pb, r_pg, r_pr;
    logic [1:0]        r_pn;
    logic              r_par, r_last_p;

    // Block totals.
    logic [9:0]        r_tb, r_tg, r_tr;
    logic [2:0]        r_tn;
    logic              r_clr, r_last_t;

    // Result register.
    logic [CHAN_W-1:0] r_ob, r_og, r_or, r_oa;
    logic              r_olast;

    logic [WW-1:0]     c_w, c_wv;
    logic [HW-1:0]     c_h, c_hv;
    logic [XW-1:0]     c_x_raw, c_x, c_ox;
    logic [ROW_W-1:0]  c_y_raw, c_y, c_oy;
    logic [WW-1:0]     c_x_inc;
    logic [HW-1:0]     c_y_inc;
    logic [AW-1:0]     c_slot;
    logic              c_counted;
    logic [PAIR_W-1:0] c_sb, c_sg, c_sr;
    logic [1:0]        c_sn;
    logic [9:0]        c_tb, c_tg, c_tr;
    logic [2:0]        c_tn;
    logic              c_wr, c_hold;

    // Effective size: bit 0 cleared, then saturated into the legal range.
    always_comb begin
        c_wv = WW'({i_cfg.image_width[CFG_W-1:1], 1'b0});
        if (c_wv < WW'(2)) begin
            c_w = WW'(2);
        end else if (c_wv > WW'(MAX_WIDTH)) begin
            c_w = WW'(MAX_WIDTH);
        end else begin
            c_w = c_wv;
        end
        c_hv = {i_cfg.image_height[CFG_W-1:1], 1'b0};
        if (c_hv < HW'(2)) begin
            c_h = HW'(2);
        end else if (c_hv > HW'(HEIGHT_LIMIT)) begin
            c_h = HW'(HEIGHT_LIMIT);
        end else begin
            c_h = c_hv;
        end
    end

    // Current position; a stale count left by a size change reads as zero.
    always_comb begin
        c_x_raw = i_first_of_image ? '0 : r_col;
        c_y_raw = i_first_of_image ? '0 : r_row;
        c_x     = (WW'(c_x_raw) >= c_w) ? '0 : c_x_raw;
        c_y     = (HW'(c_y_raw) >= c_h) ? '0 : c_y_raw;
        c_ox    = c_x >> 1;
        c_oy    = c_y >> 1;
        c_slot  = AW'(c_ox);
        c_x_inc = WW'(c_x) + WW'(1);
        c_y_inc = HW'(c_y) + HW'(1);
        if (c_x_inc >= c_w) begin
            n_col = '0;
            n_row = (c_y_inc >= c_h) ? '0 : c_y_inc[ROW_W-1:0];
        end else begin
            n_col = c_x_inc[XW-1:0];
            n_row = c_y;
        end
    end

    // Horizontal pair sum of the held pixel and the current one.
    always_comb begin
        c_counted = !i_cfg.has_alpha || (i_in_alpha == OPAQUE);
        c_sb = (r_hold_cnt ? PAIR_W'(r_hold_pix[7:0])   : '0)
             + (c_counted  ? PAIR_W'(i_in_blue)         : '0);
        c_sg = (r_hold_cnt ? PAIR_W'(r_hold_pix[15:8])  : '0)
             + (c_counted  ? PAIR_W'(i_in_green)        : '0);
        c_sr = (r_hold_cnt ? PAIR_W'(r_hold_pix[23:16]) : '0)
             + (c_counted  ? PAIR_W'(i_in_red)          : '0);
        c_sn = 2'(r_hold_cnt) + 2'(c_counted);
        c_hold = i_cmd.accept && !c_x[0];
        c_wr   = i_cmd.accept && c_x[0] && !c_y[0];
    end

    assign o_status.produce = c_x[0] && c_y[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_hold_cnt <= 1'b0;
        end else if (i_cmd.accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (c_hold) begin
                r_hold_cnt <= c_counted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_hold) begin
            r_hold_pix <= {i_in_red, i_in_green, i_in_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_wr) begin
            r_mem[c_slot] <= {c_sn, c_sr, c_sg, c_sb};
        end
        if (i_cmd.accept) begin
            r_rd <= r_mem[c_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_status.produce) begin
            r_pb     <= c_sb;
            r_pg     <= c_sg;
            r_pr     <= c_sr;
            r_pn     <= c_sn;
            r_par    <= c_ox[0] ^ c_oy[0];
            r_last_p <= (WW'(c_x) == c_w - WW'(1)) && (HW'(c_y) == c_h - HW'(1));
        end
    end

    // Merge with the upper-row sums read from the line store.
    always_comb begin
        c_tb = 10'(r_pb) + 10'(r_rd[PAIR_W-1:0]);
        c_tg = 10'(r_pg) + 10'(r_rd[2*PAIR_W-1:PAIR_W]);
        c_tr = 10'(r_pr) + 10'(r_rd[3*PAIR_W-1:2*PAIR_W]);
        c_tn = 3'(r_pn) + 3'(r_rd[SUM_W-1:3*PAIR_W]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.combine) begin
            r_tb     <= c_tb;
            r_tg     <= c_tg;
            r_tr     <= c_tr;
            r_tn     <= c_tn;
            // Two counted pixels leave a checkerboard of transparent blocks.
            r_clr    <= (c_tn < 3'd2) || (c_tn == 3'd2 && !r_par);
            r_last_t <= r_last_p;
        end
    end

    function automatic logic [CHAN_W-1:0] average(input logic [9:0] sum,
                                                  input logic [2:0] cnt);
        logic [CHAN_W-1:0] q;
        unique case (cnt)
            3'd2:    q = sum[8:1];
            3'd3:    q = div3(sum);
            3'd4:    q = sum[9:2];
            default: q = '0;
        endcase
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_olast <= r_last_t;
            if (r_clr) begin
                r_ob <= '0;
                r_og <= '0;
                r_or <= '0;
                r_oa <= i_cfg.has_alpha ? '0 : OPAQUE;
            end else begin
                r_ob <= average(r_tb, r_tn);
                r_og <= average(r_tg, r_tn);
                r_or <= average(r_tr, r_tn);
                r_oa <= OPAQUE;
            end
        end
    end

    assign o_out_blue      = r_ob;
    assign o_out_green     = r_og;
    assign o_out_red       = r_or;
    assign o_out_alpha     = r_oa;
    assign o_last_of_image = r_olast;

endmodule

// ----- hw/rtl/aamd_ctrl.sv -----
module aamd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_m_tready,
    input  aamd_pkg::t_status i_status,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    output aamd_pkg::t_cmd    o_cmd
);
    import aamd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   c_out_free;

    assign c_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && i_status.produce) begin
                    n_state = S_COMBINE;
                end
            end
            S_COMBINE: n_state = S_FINISH;
            S_FINISH: begin
                if (c_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.combine  = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            S_COMBINE: o_cmd.combine = 1'b1;
            S_FINISH:  o_cmd.load_out = c_out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    a_combine_then_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMBINE |=> r_state == S_FINISH)
        else $error("merge step not followed by result step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten while still pending");

    a_block_close_starts_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept && i_status.produce |=> r_state == S_COMBINE)
        else $error("block-closing item did not start a merge");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_m_tvalid)
        else $error("loaded result not presented");

endmodule

// ----- hw/rtl/alpha_aware_mipmap_downsample.sv -----
// Channel   Dir  Handshake              Payload
// s (pix)   in   i_s_tvalid/o_s_tready  tdata {alpha,red,green,blue}, tuser first_of_image
// m (pix)   out  o_m_tvalid/i_m_tready  tdata {alpha,red,green,blue}, tlast last_of_image
// cfg       in   i_cfg_we               i_cfg_index, i_cfg_data (no read-back)
//
// An item that does not close a 2x2 block is taken while the control is idle. An item
// that closes a block passes through three steps: accept with line-store read, merge
// with the upper-row sums, then the divide into the result register; the single-port
// line store and this merge sequence make these separate steps.
// Reset is synchronous and clears the position counters and control; the line
// store is not cleared. A stalled output holds its result while pixels that
// close no block are still taken; a block-closing item waits for the register.
module alpha_aware_mipmap_downsample #(
    parameter int MAX_WIDTH = aamd_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // blue [7:0], green [15:8], red [23:16], alpha [31:24]
    input  logic [aamd_pkg::TDATA_W-1:0] i_s_tdata,
    // first_of_image [0]
    input  logic                         i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // out_blue [7:0], out_green [15:8], out_red [23:16], out_alpha [31:24]
    output logic [aamd_pkg::TDATA_W-1:0] o_m_tdata,
    output logic                         o_m_tlast,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [aamd_pkg::CFG_W-1:0]   i_cfg_data
);
    import aamd_pkg::*;

    t_cfg              cfg;
    t_cmd              cmd;
    t_status           status;
    logic [CHAN_W-1:0] out_blue, out_green, out_red, out_alpha;

    aamd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    aamd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    aamd_dpath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .i_first_of_image (i_s_tuser),
        .i_in_blue        (i_s_tdata[7:0]),
        .i_in_green       (i_s_tdata[15:8]),
        .i_in_red         (i_s_tdata[23:16]),
        .i_in_alpha       (i_s_tdata[31:24]),
        .o_status         (status),
        .o_out_blue       (out_blue),
        .o_out_green      (out_green),
        .o_out_red        (out_red),
        .o_out_alpha      (out_alpha),
        .o_last_of_image  (o_m_tlast)
    );

    assign o_m_tdata = {out_alpha, out_red, out_green, out_blue};

endmodule
